FILE: src/sclid_pkg.sv
package sclid_pkg;

  localparam int unsigned MapSize = 58;

  localparam logic [7:0] SC_ESC    = 8'h01;
  localparam logic [7:0] SC_LSHIFT = 8'h2A;
  localparam logic [7:0] SC_RSHIFT = 8'h36;
  localparam logic [7:0] SC_PFX_E0 = 8'hE0;
  localparam logic [7:0] SC_PFX_E1 = 8'hE1;

  localparam logic [6:0] ASCII_NONE = 7'h00;
  localparam logic [6:0] ASCII_BS   = 7'h08;
  localparam logic [6:0] ASCII_LF   = 7'h0A;

  localparam logic [6:0] MAX_LINE_RESET = 7'd79;

  typedef enum logic [1:0] {
    EV_CHAR  = 2'd0,
    EV_ERASE = 2'd1,
    EV_EOL   = 2'd2,
    EV_EXIT  = 2'd3
  } event_kind_e;

  typedef struct packed {
    event_kind_e kind;
    logic [6:0]  character;
    logic [6:0]  position;
    logic [6:0]  line_length;
  } result_t;

  // US layout, scan code set 1, indexed by make code.
  localparam logic [6:0] PLAIN_MAP [MapSize] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [6:0] SHIFT_MAP [MapSize] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

endpackage

FILE: src/sclid_in_stage.sv
module sclid_in_stage
  import sclid_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] scan_code_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] scan_code_o
);

  logic       valid_q, valid_d;
  logic [7:0] scan_q;

  // The stage refills in the same cycle that its beat moves on.
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      scan_q <= scan_code_i;
    end
  end

  assign valid_o     = valid_q;
  assign scan_code_o = scan_q;

endmodule

FILE: src/sclid_keymap.sv
module sclid_keymap
  import sclid_pkg::*;
(
  input  logic [7:0] scan_code_i,
  input  logic       shift_i,
  output logic [6:0] ascii_o
);

  logic [5:0] idx;

  assign idx = scan_code_i[5:0];

  always_comb begin
    ascii_o = ASCII_NONE;
    if (scan_code_i < 8'(MapSize)) begin
      ascii_o = shift_i ? SHIFT_MAP[idx] : PLAIN_MAP[idx];
    end
  end

endmodule

FILE: src/sclid_core.sv
module sclid_core
  import sclid_pkg::*;
#(
  parameter int unsigned LINE_CAPACITY = 80
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] scan_code_i,
  input  logic [6:0] max_line_i,
  output logic       take_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    result_o
);

  localparam logic [6:0] CapLimit = 7'(LINE_CAPACITY - 1);

  logic       shift_q, shift_d;
  logic [6:0] held_q, held_d;
  logic [6:0] count_q, count_d;
  logic       out_valid_q, out_valid_d;
  result_t    result_q, res;
  logic       emit;
  logic [6:0] ascii;
  logic [6:0] limit;
  logic [7:0] sc;

  assign sc     = scan_code_i;
  assign take_o = valid_i && (!out_valid_q || out_ready_i);
  assign limit  = (max_line_i < CapLimit) ? max_line_i : CapLimit;

  sclid_keymap u_keymap (
    .scan_code_i (sc),
    .shift_i     (shift_q),
    .ascii_o     (ascii)
  );

  always_comb begin
    shift_d         = shift_q;
    held_d          = held_q;
    count_d         = count_q;
    emit            = 1'b0;
    res.kind        = EV_CHAR;
    res.character   = 7'd0;
    res.position    = 7'd0;
    res.line_length = count_q;
    if (sc == SC_PFX_E0 || sc == SC_PFX_E1) begin
      emit = 1'b0;
    end else if (sc == SC_ESC) begin
      emit     = 1'b1;
      res.kind = EV_EXIT;
    end else if (sc[7]) begin
      if (sc[6:0] == SC_LSHIFT[6:0] || sc[6:0] == SC_RSHIFT[6:0]) begin
        shift_d = 1'b0;
      end
      if (sc[6:0] == held_q) begin
        held_d = 7'd0;
      end
    end else if (sc == 8'd0) begin
      emit = 1'b0;
    end else if (sc == SC_LSHIFT || sc == SC_RSHIFT) begin
      shift_d = 1'b1;
    end else if (sc[6:0] == held_q) begin
      // Auto-repeat of the key already down is dropped.
      emit = 1'b0;
    end else begin
      held_d = sc[6:0];
      if (ascii == ASCII_LF) begin
        emit     = 1'b1;
        res.kind = EV_EOL;
        count_d  = 7'd0;
      end else if (ascii == ASCII_BS) begin
        if (count_q != 7'd0) begin
          emit            = 1'b1;
          res.kind        = EV_ERASE;
          count_d         = count_q - 7'd1;
          res.position    = count_d;
          res.line_length = count_d;
        end
      end else if (ascii != ASCII_NONE && count_q < limit) begin
        emit            = 1'b1;
        res.kind        = EV_CHAR;
        res.character   = ascii;
        res.position    = count_q;
        count_d         = count_q + 7'd1;
        res.line_length = count_d;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= 1'b0;
      held_q      <= 7'd0;
      count_q     <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        shift_q <= shift_d;
        held_q  <= held_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      result_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

FILE: src/scancode_line_input_decoder_top.sv
// Line input decoder for PS/2 scan code set 1 bytes.
// The input channel (in_valid_i/in_ready_o, scan_code_i) takes one raw byte
// per beat. Prefix bytes, zero bytes and auto-repeats leave the state as it is;
// shift keys, releases and unmapped keys update it; none of these give a result beat.
// The output channel (out_valid_o/out_ready_i) carries one event per beat:
// a typed character with its position, an erase, an end of line with its
// length, or an exit request.
// The configuration channel (cfg_valid_i/cfg_ready_o, max_line_i) sets the
// line limit; it is always ready and should be written only while idle.
// An input beat passes through the input register and then the decode stage,
// which loads the result register.
// Throughput is one byte per cycle while the receiver does not stall; the key table lookup and the line
// counter update form the single decode step between the two registers.
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more byte; after that in_ready_o drops.
// Reset clears shift, held key and line count, empties both registers and
// sets the line limit to 79.
module scancode_line_input_decoder_top
  import sclid_pkg::*;
#(
  parameter int unsigned LINE_CAPACITY = 80
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] scan_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] event_kind_o,
  output logic [6:0] character_o,
  output logic [6:0] position_o,
  output logic [6:0] line_length_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] max_line_i
);

  logic [6:0] max_line_q;
  logic       take;
  logic       s1_valid;
  logic [7:0] s1_scan;
  result_t    result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q <= MAX_LINE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_line_q <= max_line_i;
    end
  end

  sclid_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .scan_code_i (scan_code_i),
    .take_i      (take),
    .valid_o     (s1_valid),
    .scan_code_o (s1_scan)
  );

  sclid_core #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .scan_code_i (s1_scan),
    .max_line_i  (max_line_q),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign event_kind_o  = result.kind;
  assign character_o   = result.character;
  assign position_o    = result.position;
  assign line_length_o = result.line_length;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sclid_pkg::*;

  localparam int unsigned KEYMAP_LEN   = 58;
  localparam logic [6:0]  LINE_MAX     = 7'd79;
  localparam int unsigned DRAIN_CYCLES = 4;

  localparam logic [7:0] SC_NONE      = 8'h00;
  localparam logic [7:0] SC_RELEASE   = 8'h80;
  localparam logic [7:0] SC_BACKSPACE = 8'h0E;
  localparam logic [7:0] SC_ENTER     = 8'h1C;
  localparam logic [7:0] SC_CTRL      = 8'h1D;
  localparam logic [7:0] SC_KEY_1     = 8'h02;
  localparam logic [7:0] SC_KEY_Q     = 8'h10;
  localparam logic [7:0] SC_KEY_P     = 8'h19;
  localparam logic [7:0] SC_KEY_A     = 8'h1E;
  localparam logic [7:0] SC_KEY_S     = 8'h1F;
  localparam logic [7:0] SC_TOP_MAKE  = 8'h7F;

  // US layout for set 1 make codes, unshifted and shifted.
  localparam logic [6:0] PLAIN_KEYS [KEYMAP_LEN] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [6:0] SHIFTED_KEYS [KEYMAP_LEN] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] scan_code_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] event_kind_o;
  logic [6:0] character_o;
  logic [6:0] position_o;
  logic [6:0] line_length_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [6:0] max_line_i  = '0;

  // Keyboard and line state as the block should hold it.
  logic       kbd_shift    = 1'b0;
  logic [6:0] kbd_held     = '0;
  logic [6:0] kbd_line_len = '0;
  logic [6:0] kbd_max_line = LINE_MAX;

  result_t     expected_events [$];
  result_t     next_event;
  int unsigned mismatches    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 64;
  int unsigned rx_hold_len   = 0;
  int unsigned rx_hold_left  = 0;

  scancode_line_input_decoder_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .scan_code_i  (scan_code_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_kind_o (event_kind_o),
    .character_o  (character_o),
    .position_o   (position_o),
    .line_length_o(line_length_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .max_line_i   (max_line_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Advances the line state by one scan code byte; returns 1 when an event is due.
  function automatic bit decode_key_byte(input logic [7:0] code, output result_t ev);
    logic [6:0] ascii;
    logic [6:0] limit;
    ev = '0;
    if (code == SC_PFX_E0 || code == SC_PFX_E1) return 1'b0;
    if (code == SC_ESC) begin
      ev.kind        = EV_EXIT;
      ev.line_length = kbd_line_len;
      return 1'b1;
    end
    if ((code & SC_RELEASE) != SC_NONE) begin
      if (code[6:0] == SC_LSHIFT[6:0] || code[6:0] == SC_RSHIFT[6:0]) kbd_shift = 1'b0;
      if (code[6:0] == kbd_held) kbd_held = '0;
      return 1'b0;
    end
    if (code == SC_NONE) return 1'b0;
    if (code == SC_LSHIFT || code == SC_RSHIFT) begin
      kbd_shift = 1'b1;
      return 1'b0;
    end
    // Auto-repeat of the key already down is dropped.
    if (code[6:0] == kbd_held) return 1'b0;
    kbd_held = code[6:0];
    if (code >= KEYMAP_LEN) return 1'b0;
    ascii = kbd_shift ? SHIFTED_KEYS[code] : PLAIN_KEYS[code];
    if (ascii == ASCII_NONE) return 1'b0;
    if (ascii == ASCII_LF) begin
      ev.kind        = EV_EOL;
      ev.line_length = kbd_line_len;
      kbd_line_len   = '0;
      return 1'b1;
    end
    if (ascii == ASCII_BS) begin
      if (kbd_line_len == '0) return 1'b0;
      kbd_line_len   = kbd_line_len - 7'd1;
      ev.kind        = EV_ERASE;
      ev.position    = kbd_line_len;
      ev.line_length = kbd_line_len;
      return 1'b1;
    end
    limit = (kbd_max_line > LINE_MAX) ? LINE_MAX : kbd_max_line;
    if (kbd_line_len >= limit) return 1'b0;
    ev.kind        = EV_CHAR;
    ev.character   = ascii;
    ev.position    = kbd_line_len;
    kbd_line_len   = kbd_line_len + 7'd1;
    ev.line_length = kbd_line_len;
    return 1'b1;
  endfunction

  task automatic send_scan_code(input logic [7:0] code);
    result_t ev;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    scan_code_i <= code;
    do @(posedge clk_i); while (!in_ready_o);
    if (decode_key_byte(code, ev)) expected_events.push_back(ev);
    if (code != SC_PFX_E0 && code != SC_PFX_E1 && code != SC_NONE) bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    // Bytes that give no event may still be in the pipeline.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_line(input logic [6:0] value);
    cfg_valid_i <= 1'b1;
    max_line_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    kbd_max_line = value;
  endtask

  task automatic send_keystroke(input int unsigned enter_pct);
    int unsigned pick;
    logic [7:0]  key;
    pick = $urandom_range(99);
    if (pick < 6) begin
      send_scan_code(8'($urandom_range(255)));
    end else if (pick < 6 + enter_pct) begin
      send_scan_code(SC_ENTER);
      send_scan_code(SC_ENTER | SC_RELEASE);
    end else if (pick < 11 + enter_pct) begin
      send_scan_code(SC_BACKSPACE);
      send_scan_code(SC_BACKSPACE | SC_RELEASE);
    end else if (pick < 19 + enter_pct) begin
      key = $urandom_range(1) ? SC_LSHIFT : SC_RSHIFT;
      if ($urandom_range(1)) key = key | SC_RELEASE;
      send_scan_code(key);
    end else if (pick < 23 + enter_pct) begin
      send_scan_code(pick[0] ? SC_PFX_E0 : SC_PFX_E1);
    end else if (pick < 25 + enter_pct) begin
      send_scan_code(SC_ESC);
    end else begin
      key = 8'($urandom_range(2, KEYMAP_LEN - 1));
      send_scan_code(key);
      if ($urandom_range(99) < 15) send_scan_code(key);
      if ($urandom_range(99) < 85) send_scan_code(key | SC_RELEASE);
    end
  endtask

  task automatic test_special_bytes();
    send_scan_code(SC_NONE);
    send_scan_code(SC_PFX_E0);
    send_scan_code(SC_PFX_E1);
    send_scan_code(8'hFF);
    send_scan_code(SC_ESC);
  endtask

  task automatic test_shift_and_repeat();
    send_scan_code(SC_LSHIFT);
    send_scan_code(SC_KEY_Q);
    send_scan_code(SC_KEY_Q);
    send_scan_code(SC_KEY_Q | SC_RELEASE);
    send_scan_code(SC_LSHIFT | SC_RELEASE);
    send_scan_code(SC_RSHIFT);
    send_scan_code(SC_KEY_1);
    send_scan_code(SC_RSHIFT | SC_RELEASE);
    send_scan_code(SC_KEY_1 | SC_RELEASE);
    send_scan_code(SC_KEY_1);
    send_scan_code(SC_CTRL);
    send_scan_code(SC_TOP_MAKE);
  endtask

  task automatic test_line_edit();
    send_scan_code(SC_BACKSPACE);
    send_scan_code(SC_BACKSPACE | SC_RELEASE);
    send_scan_code(SC_BACKSPACE);
    send_scan_code(SC_ENTER);
    send_scan_code(SC_BACKSPACE | SC_RELEASE);
    send_scan_code(SC_BACKSPACE);
  endtask

  task automatic test_line_limit();
    wait_drained();
    write_max_line(7'd0);
    send_scan_code(SC_KEY_A);
    wait_drained();
    write_max_line(7'd1);
    send_scan_code(SC_KEY_S);
    send_scan_code(SC_KEY_A);
    send_scan_code(SC_ENTER);
  endtask

  // The receiver stalls long enough for the block to fill and hold off input.
  task automatic test_output_stall();
    int unsigned n;
    logic [7:0]  key;
    wait_drained();
    write_max_line(LINE_MAX);
    rx_hold_len = 300;
    for (n = 0; n < 24; n++) begin
      key = 8'($urandom_range(SC_KEY_Q, SC_KEY_P));
      send_scan_code(key);
      send_scan_code(key | SC_RELEASE);
    end
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned tx_idle, input int unsigned rx_idle,
                                     input logic [6:0] limit, input int unsigned enter_pct,
                                     input int unsigned count);
    int unsigned stop_at;
    wait_drained();
    write_max_line(limit);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) send_keystroke(enter_pct);
  endtask

  always @(posedge clk_i) begin
    if (rx_hold_len != 0) begin
      rx_hold_left = rx_hold_len;
      rx_hold_len  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event beat: event_kind %0d character %0h", event_kind_o,
               character_o);
        mismatches++;
      end else begin
        next_event = expected_events.pop_front();
        if (event_kind_o != next_event.kind) begin
          $error("event_kind: expected %0d, got %0d", next_event.kind, event_kind_o);
          mismatches++;
        end
        if (character_o != next_event.character) begin
          $error("character: expected %0h, got %0h", next_event.character, character_o);
          mismatches++;
        end
        if (position_o != next_event.position) begin
          $error("position: expected %0d, got %0d", next_event.position, position_o);
          mismatches++;
        end
        if (line_length_o != next_event.line_length) begin
          $error("line_length: expected %0d, got %0d", next_event.line_length,
                 line_length_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_bytes();
    test_shift_and_repeat();
    test_line_edit();
    test_line_limit();
    test_output_stall();
    test_random_traffic(18, 64, 7'($urandom_range(13, 78)), 8, 390);
    test_random_traffic(64, 18, 7'($urandom_range(1, 12)), 4, 390);
    test_random_traffic(0, 0, 7'd127, 1, 390);
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (expected_events.size() != 0) begin
      $error("%0d expected events never arrived", expected_events.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("scancode_line_input_decoder_top regression: pass");
    end else begin
      $display("scancode_line_input_decoder_top regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $error("timeout waiting for the block");
    $display("scancode_line_input_decoder_top regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
src/sclid_pkg.sv
src/sclid_in_stage.sv
src/sclid_keymap.sv
src/sclid_core.sv
src/scancode_line_input_decoder_top.sv
sim/testbench.sv
